// ===== hdl/ers_pkg.sv =====
// ----------------------------------------------------------------------------
// ers_pkg
// Shared constants, codes and types for the elevator request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int SECTOR_BITS = 32;
	localparam int TAG_BITS    = 8;

	localparam int POS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	localparam int FLD_SECTOR_W = 32;
	localparam int FLD_COUNT_W  = 8;
	localparam int FLD_TAG_W    = 8;
	localparam int FLD_ERROR_W  = 2;
	localparam int FLD_PEND_W   = 5;

	localparam logic ACT_SUBMIT   = 1'b0;
	localparam logic ACT_COMPLETE = 1'b1;

	localparam logic [FLD_ERROR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [FLD_ERROR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [FLD_ERROR_W-1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} ers_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/elevator_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// elevator_request_scheduler
// Elevator (SCAN) scheduler for one block-device queue: sorted request table,
// grant of the next request in the current sweep direction.
// ----------------------------------------------------------------------------
//  channel   control          payload
//  command   start / busy     action, sector, block_count, is_write, tag
//  result    done (strobe)    grant_valid, grant_tag, grant_sector,
//                             grant_count, grant_is_write, error, pending
//
//  A command runs as a capture with per-cell sector compare, then one
//  parallel shift of the table cells; the result strobe follows in the next
//  cycle, in which busy drops and the next command may transfer.
//  Reset empties the table; no clearing pass is needed.
//  The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_request_scheduler (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                action,
	input  wire logic [ers_pkg::FLD_SECTOR_W-1:0]    sector,
	input  wire logic [ers_pkg::FLD_COUNT_W-1:0]     block_count,
	input  wire logic                                is_write,
	input  wire logic [ers_pkg::FLD_TAG_W-1:0]       tag,
	output logic                                     done,
	output logic                                     grant_valid,
	output logic [ers_pkg::FLD_TAG_W-1:0]            grant_tag,
	output logic [ers_pkg::FLD_SECTOR_W-1:0]         grant_sector,
	output logic [ers_pkg::FLD_COUNT_W-1:0]          grant_count,
	output logic                                     grant_is_write,
	output logic [ers_pkg::FLD_ERROR_W-1:0]          error,
	output logic [ers_pkg::FLD_PEND_W-1:0]           pending
);

	ers_pkg::ers_cmd_t cmd;

	ers_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ers_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.action         (action),
		.sector         (sector),
		.block_count    (block_count),
		.is_write       (is_write),
		.tag            (tag),
		.done           (done),
		.grant_valid    (grant_valid),
		.grant_tag      (grant_tag),
		.grant_sector   (grant_sector),
		.grant_count    (grant_count),
		.grant_is_write (grant_is_write),
		.error          (error),
		.pending        (pending)
	);

endmodule

`default_nettype wire

// ===== hdl/ers_ctrl.sv =====
// ----------------------------------------------------------------------------
// ers_ctrl
// Sequencer: captures a command, then runs one table update step.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output ers_pkg::ers_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ers_dp.sv =====
// ----------------------------------------------------------------------------
// ers_dp
// Sorted request table with per-cell compare and shift, sweep state and
// registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ers_pkg::ers_cmd_t                   cmd,
	input  wire logic                                action,
	input  wire logic [ers_pkg::FLD_SECTOR_W-1:0]    sector,
	input  wire logic [ers_pkg::FLD_COUNT_W-1:0]     block_count,
	input  wire logic                                is_write,
	input  wire logic [ers_pkg::FLD_TAG_W-1:0]       tag,
	output logic                                     done,
	output logic                                     grant_valid,
	output logic [ers_pkg::FLD_TAG_W-1:0]            grant_tag,
	output logic [ers_pkg::FLD_SECTOR_W-1:0]         grant_sector,
	output logic [ers_pkg::FLD_COUNT_W-1:0]          grant_count,
	output logic                                     grant_is_write,
	output logic [ers_pkg::FLD_ERROR_W-1:0]          error,
	output logic [ers_pkg::FLD_PEND_W-1:0]           pending
);

	localparam int QD  = ers_pkg::QUEUE_DEPTH;
	localparam int SW  = ers_pkg::SECTOR_BITS;
	localparam int TW  = ers_pkg::TAG_BITS;
	localparam int PW  = ers_pkg::POS_W;
	localparam int OW  = ers_pkg::OCC_W;
	localparam int CW  = ers_pkg::FLD_COUNT_W;

	// table cells
	logic [SW-1:0] sec_q [QD];
	logic [CW-1:0] cnt_q [QD];
	logic          wr_q  [QD];
	logic [TW-1:0] tag_q [QD];

	logic [OW-1:0] occ_q;
	logic [PW-1:0] run_q;
	logic          down_q;

	// captured command
	logic          act_q;
	logic [SW-1:0] in_sec_q;
	logic [CW-1:0] in_cnt_q;
	logic          in_wr_q;
	logic [TW-1:0] in_tag_q;
	logic [QD-1:0] le_q;

	// result registers
	logic                                done_q;
	logic                                gv_q;
	logic [ers_pkg::FLD_TAG_W-1:0]       gtag_q;
	logic [ers_pkg::FLD_SECTOR_W-1:0]    gsec_q;
	logic [CW-1:0]                       gcnt_q;
	logic                                gwr_q;
	logic [ers_pkg::FLD_ERROR_W-1:0]     err_q;
	logic [ers_pkg::FLD_PEND_W-1:0]      pend_q;

	logic [QD-1:0] prev_le;
	logic [QD-1:0] ins_here;

	logic          ins;
	logic          rem;
	logic          empty;
	logic          full;
	logic          at_top;
	logic          at_bot;
	logic          d_next;
	logic          has_next;
	logic [PW-1:0] nxt_idx;
	logic [OW-1:0] occ_d;
	logic [PW-1:0] run_d;
	logic          down_d;
	logic          gv_d;
	logic [TW-1:0] gtag_d;
	logic [SW-1:0] gsec_d;
	logic [CW-1:0] gcnt_d;
	logic          gwr_d;
	logic [ers_pkg::FLD_ERROR_W-1:0] err_d;

	// insert point is the first cell whose sector is above the new one, or the first free cell
	assign prev_le  = {le_q[QD-2:0], 1'b1};
	assign ins_here = prev_le & ~le_q;

	always_comb begin
		empty    = (occ_q == '0);
		full     = (occ_q == OW'(QD));
		at_top   = ((OW'(run_q) + OW'(1)) == occ_q);
		at_bot   = (run_q == '0);
		d_next   = down_q;
		if (!down_q && at_top) begin
			d_next = 1'b1;
		end else if (down_q && at_bot) begin
			d_next = 1'b0;
		end
		has_next = d_next ? !at_bot : !at_top;
		nxt_idx  = d_next ? (run_q - PW'(1)) : (run_q + PW'(1));

		ins    = 1'b0;
		rem    = 1'b0;
		occ_d  = occ_q;
		run_d  = run_q;
		down_d = down_q;
		gv_d   = 1'b0;
		gtag_d = '0;
		gsec_d = '0;
		gcnt_d = '0;
		gwr_d  = 1'b0;
		err_d  = ers_pkg::ERR_NONE;

		if (act_q == ers_pkg::ACT_SUBMIT) begin
			if (full) begin
				err_d = ers_pkg::ERR_FULL;
			end else begin
				ins   = 1'b1;
				occ_d = occ_q + OW'(1);
				if (empty) begin
					run_d  = '0;
					gv_d   = 1'b1;
					gtag_d = in_tag_q;
					gsec_d = in_sec_q;
					gcnt_d = in_cnt_q;
					gwr_d  = in_wr_q;
				end else if (!le_q[run_q]) begin
					run_d = run_q + PW'(1);
				end
			end
		end else begin
			if (empty) begin
				err_d = ers_pkg::ERR_EMPTY;
			end else begin
				rem    = 1'b1;
				occ_d  = occ_q - OW'(1);
				down_d = d_next;
				if (has_next) begin
					gv_d   = 1'b1;
					gtag_d = tag_q[nxt_idx];
					gsec_d = sec_q[nxt_idx];
					gcnt_d = cnt_q[nxt_idx];
					gwr_d  = wr_q[nxt_idx];
					run_d  = d_next ? (run_q - PW'(1)) : run_q;
				end else begin
					run_d = '0;
				end
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < QD; gi++) begin : g_cell
			always_ff @(posedge clk) begin
				if (cmd.load) begin
					le_q[gi] <= (OW'(gi) < occ_q) && (sec_q[gi] <= SW'(sector));
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.exec && ins) begin
					if (ins_here[gi]) begin
						sec_q[gi] <= in_sec_q;
						cnt_q[gi] <= in_cnt_q;
						wr_q[gi]  <= in_wr_q;
						tag_q[gi] <= in_tag_q;
					end else if (!le_q[gi]) begin
						if (gi > 0) begin
							sec_q[gi] <= sec_q[(gi > 0) ? gi - 1 : 0];
							cnt_q[gi] <= cnt_q[(gi > 0) ? gi - 1 : 0];
							wr_q[gi]  <= wr_q[(gi > 0) ? gi - 1 : 0];
							tag_q[gi] <= tag_q[(gi > 0) ? gi - 1 : 0];
						end
					end
				end else if (cmd.exec && rem) begin
					if ((gi < QD - 1) && (PW'(gi) >= run_q)) begin
						sec_q[gi] <= sec_q[(gi < QD - 1) ? gi + 1 : gi];
						cnt_q[gi] <= cnt_q[(gi < QD - 1) ? gi + 1 : gi];
						wr_q[gi]  <= wr_q[(gi < QD - 1) ? gi + 1 : gi];
						tag_q[gi] <= tag_q[(gi < QD - 1) ? gi + 1 : gi];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			in_sec_q <= SW'(sector);
			in_cnt_q <= block_count;
			in_wr_q  <= is_write;
			in_tag_q <= TW'(tag);
		end
		if (cmd.exec) begin
			gv_q   <= gv_d;
			gtag_q <= ers_pkg::FLD_TAG_W'(gtag_d);
			gsec_q <= ers_pkg::FLD_SECTOR_W'(gsec_d);
			gcnt_q <= gcnt_d;
			gwr_q  <= gwr_d;
			err_q  <= err_d;
			pend_q <= ers_pkg::FLD_PEND_W'(occ_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			run_q  <= '0;
			down_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				occ_q  <= occ_d;
				run_q  <= run_d;
				down_q <= down_d;
			end
		end
	end

	assign done           = done_q;
	assign grant_valid    = gv_q;
	assign grant_tag      = gtag_q;
	assign grant_sector   = gsec_q;
	assign grant_count    = gcnt_q;
	assign grant_is_write = gwr_q;
	assign error          = err_q;
	assign pending        = pend_q;

endmodule

`default_nettype wire

// ===== tb/sv/ers_grant_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_grant_monitor
// Watches the command and result channels of the elevator request scheduler.
// It keeps its own sorted request table and sweep state, and works out the
// grant of every accepted command. Each result strobe is checked field by
// field against the oldest grant still owed.
// ----------------------------------------------------------------------------

module ers_grant_monitor
	import ers_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic                    action,
	input  logic [FLD_SECTOR_W-1:0] sector,
	input  logic [FLD_COUNT_W-1:0]  block_count,
	input  logic                    is_write,
	input  logic [FLD_TAG_W-1:0]    tag,
	input  logic                    done,
	input  logic                    grant_valid,
	input  logic [FLD_TAG_W-1:0]    grant_tag,
	input  logic [FLD_SECTOR_W-1:0] grant_sector,
	input  logic [FLD_COUNT_W-1:0]  grant_count,
	input  logic                    grant_is_write,
	input  logic [FLD_ERROR_W-1:0]  error,
	input  logic [FLD_PEND_W-1:0]   pending,
	output int                      mismatch_count,
	output int                      grants_owed
);

	typedef struct packed {
		logic [FLD_SECTOR_W-1:0] sec;
		logic [FLD_COUNT_W-1:0]  cnt;
		logic                    wr;
		logic [FLD_TAG_W-1:0]    tg;
	} queue_slot_t;

	typedef struct packed {
		logic                    gv;
		logic [FLD_TAG_W-1:0]    tg;
		logic [FLD_SECTOR_W-1:0] sec;
		logic [FLD_COUNT_W-1:0]  cnt;
		logic                    wr;
		logic [FLD_ERROR_W-1:0]  err;
		logic [FLD_PEND_W-1:0]   pend;
	} grant_t;

	queue_slot_t slots [QUEUE_DEPTH];
	int          fill;
	int          run_pos;
	bit          sweep_down;
	grant_t      grants_due [$];

	initial begin
		mismatch_count = 0;
		grants_owed = 0;
	end

	function automatic grant_t load_grant(int pos);
		grant_t g;
		g = '0;
		g.gv  = 1'b1;
		g.tg  = slots[pos].tg;
		g.sec = slots[pos].sec;
		g.cnt = slots[pos].cnt;
		g.wr  = slots[pos].wr;
		return g;
	endfunction

	function automatic grant_t predict_grant(logic act, logic [FLD_SECTOR_W-1:0] sec,
			logic [FLD_COUNT_W-1:0] cnt, logic wr, logic [FLD_TAG_W-1:0] tg);
		grant_t g;
		int     p;
		int     r;
		int     next_pos;
		bit     has_next;
		g = '0;
		if (act == ACT_SUBMIT) begin
			if (fill >= QUEUE_DEPTH) begin
				g.err = ERR_FULL;
			end else begin
				p = 0;
				while (p < fill && slots[p].sec <= sec)
					p++;
				for (int i = fill; i > p; i--)
					slots[i] = slots[i-1];
				slots[p] = '{sec: sec, cnt: cnt, wr: wr, tg: tg};
				if (fill == 0) begin
					run_pos = p;
					fill = 1;
					g = load_grant(p);
				end else begin
					if (p <= run_pos)
						run_pos++;
					fill++;
				end
			end
		end else begin
			if (fill == 0) begin
				g.err = ERR_EMPTY;
			end else begin
				r = (run_pos >= fill) ? fill - 1 : run_pos;
				if (!sweep_down && r + 1 == fill)
					sweep_down = 1'b1;
				else if (sweep_down && r == 0)
					sweep_down = 1'b0;
				// going up, the upper neighbour drops into slot r after removal
				if (!sweep_down) begin
					has_next = (r + 1 < fill);
					next_pos = r;
				end else begin
					has_next = (r > 0);
					next_pos = has_next ? r - 1 : 0;
				end
				for (int i = r; i + 1 < fill; i++)
					slots[i] = slots[i+1];
				fill--;
				if (has_next) begin
					run_pos = next_pos;
					g = load_grant(next_pos);
				end else begin
					run_pos = 0;
				end
			end
		end
		g.pend = fill[FLD_PEND_W-1:0];
		return g;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t ers_grant_monitor: %s mismatch, expected %0h, got %0h",
					$realtime, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			fill = 0;
			run_pos = 0;
			sweep_down = 1'b0;
			grants_due.delete();
		end else begin
			if (done === 1'b1) begin
				if (grants_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t ers_grant_monitor: result strobe with no grant owed",
							$realtime);
				end else begin
					want = grants_due.pop_front();
					check_field("grant_valid", want.gv, grant_valid);
					check_field("grant_tag", want.tg, grant_tag);
					check_field("grant_sector", want.sec, grant_sector);
					check_field("grant_count", want.cnt, grant_count);
					check_field("grant_is_write", want.wr, grant_is_write);
					check_field("error", want.err, error);
					check_field("pending", want.pend, pending);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				grants_due.push_back(predict_grant(action, sector, block_count,
					is_write, tag));
		end
		grants_owed = grants_due.size();
	end

endmodule

// ===== tb/sv/elevator_request_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_request_scheduler_tb
// Drives submit and complete commands into the elevator request scheduler:
// a directed fill, overflow and partial drain of the table, then random traffic in
// alternating fill-heavy and drain-heavy phases with clustered sectors.
// A separate monitor predicts and checks every grant.
// ----------------------------------------------------------------------------

module elevator_request_scheduler_tb;
	import ers_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASE_LEN    = 150;
	localparam int CYCLE_LIMIT  = 200000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    action;
	logic [FLD_SECTOR_W-1:0] sector;
	logic [FLD_COUNT_W-1:0]  block_count;
	logic                    is_write;
	logic [FLD_TAG_W-1:0]    tag;
	logic                    done;
	logic                    grant_valid;
	logic [FLD_TAG_W-1:0]    grant_tag;
	logic [FLD_SECTOR_W-1:0] grant_sector;
	logic [FLD_COUNT_W-1:0]  grant_count;
	logic                    grant_is_write;
	logic [FLD_ERROR_W-1:0]  error;
	logic [FLD_PEND_W-1:0]   pending;
	int                      mismatch_count;
	int                      grants_owed;
	int                      cycles;
	bit                      quiet;

	elevator_request_scheduler u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.sector         (sector),
		.block_count    (block_count),
		.is_write       (is_write),
		.tag            (tag),
		.done           (done),
		.grant_valid    (grant_valid),
		.grant_tag      (grant_tag),
		.grant_sector   (grant_sector),
		.grant_count    (grant_count),
		.grant_is_write (grant_is_write),
		.error          (error),
		.pending        (pending)
	);

	ers_grant_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.sector         (sector),
		.block_count    (block_count),
		.is_write       (is_write),
		.tag            (tag),
		.done           (done),
		.grant_valid    (grant_valid),
		.grant_tag      (grant_tag),
		.grant_sector   (grant_sector),
		.grant_count    (grant_count),
		.grant_is_write (grant_is_write),
		.error          (error),
		.pending        (pending),
		.mismatch_count (mismatch_count),
		.grants_owed    (grants_owed)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("elevator_request_scheduler_tb: FAIL");
			$finish;
		end
	end

	// holds start high until the transfer edge; the caller may issue again at once
	task automatic issue(logic act, logic [FLD_SECTOR_W-1:0] sec, logic [FLD_COUNT_W-1:0] cnt,
			logic wr, logic [FLD_TAG_W-1:0] tg);
		start       <= 1'b1;
		action      <= act;
		sector      <= sec;
		block_count <= cnt;
		is_write    <= wr;
		tag         <= tg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(99) < 13) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [FLD_SECTOR_W-1:0] pick_sector();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return FLD_SECTOR_W'($urandom_range(7) * 64);
		else if (roll < 45)
			return '0;
		else if (roll < 50)
			return '1;
		else
			return FLD_SECTOR_W'($urandom);
	endfunction

	initial begin
		int  submit_pct;
		logic act;
		start       = 1'b0;
		action      = ACT_SUBMIT;
		sector      = '0;
		block_count = '0;
		is_write    = 1'b0;
		tag         = '0;
		quiet       = 1'b0;
		arst_n      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// complete with nothing running
		issue(ACT_COMPLETE, 32'd77, 8'd3, 1'b1, 8'd9);
		// grant on empty, then inserts below, above and at the running sector
		issue(ACT_SUBMIT, 32'd1000, 8'h00, 1'b0, 8'h00);
		issue(ACT_SUBMIT, 32'h0000_0000, 8'hFF, 1'b1, 8'hFF);
		issue(ACT_SUBMIT, 32'hFFFF_FFFF, 8'h55, 1'b0, 8'hAA);
		issue(ACT_SUBMIT, 32'd1000, 8'hAA, 1'b1, 8'h55);
		issue(ACT_SUBMIT, 32'd1000, 8'h01, 1'b0, 8'h01);
		for (int i = 0; i < 11; i++)
			issue(ACT_SUBMIT, FLD_SECTOR_W'(i * 300 + 100), FLD_COUNT_W'(i + 2), i[0],
				FLD_TAG_W'(i + 16));
		// table full
		issue(ACT_SUBMIT, 32'h8000_0000, 8'h80, 1'b1, 8'h80);
		// drain upward from the running sector; the sweep does not reach the end here
		repeat (7)
			issue(ACT_COMPLETE, '0, '0, 1'b0, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 700 && n < 1000);
			submit_pct = ((n / PHASE_LEN) % 2 == 0) ? 70 : 25;
			act = ($urandom_range(99) < submit_pct) ? ACT_SUBMIT : ACT_COMPLETE;
			maybe_idle();
			issue(act, pick_sector(), FLD_COUNT_W'($urandom), 1'($urandom),
				FLD_TAG_W'($urandom));
		end
		start <= 1'b0;

		while (grants_owed != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && grants_owed == 0)
			$display("elevator_request_scheduler_tb: PASS");
		else
			$display("elevator_request_scheduler_tb: FAIL");
		$finish;
	end

endmodule
